// ===== hw/rtl/dfs_pkg.sv =====
// Shared constants, widths and control types for the decimal fixed-point square root unit.
package dfs_pkg;

    localparam int VALUE_BITS       = 31;
    localparam int MAX_FRAC_DIGITS  = 4;

    localparam int INT_ROOT_BITS    = 16;
    localparam int SCALED_ROOT_BITS = 29;
    localparam int FRAC_DIGITS_BITS = 3;
    localparam logic [FRAC_DIGITS_BITS-1:0] FRAC_DIGITS_RESET = 3'd3;

    // integer phase: one result bit per step, two value bits consumed per step
    localparam int INT_STEPS = (VALUE_BITS + 1) / 2;
    localparam int INT_IN_W  = 2 * INT_STEPS;
    localparam int STEP_W    = $clog2(INT_STEPS);

    // each decimal digit adds less than four bits to the root
    localparam int ROOT_W = INT_STEPS + 4 * MAX_FRAC_DIGITS;
    // remainder <= 2*root, times 100 during a digit step
    localparam int WORK_W = ROOT_W + 8;
    localparam int DIG_W  = $clog2(MAX_FRAC_DIGITS + 2);

    localparam int TDIG_W = 4;
    // a digit is final once the candidate 9 has been accepted
    localparam logic [TDIG_W-1:0] DIGIT_LAST_TRY = 4'd8;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_INT      = 5'b00010,
        ST_DIG_INIT = 5'b00100,
        ST_DIG_TRY  = 5'b01000,
        ST_DONE     = 5'b10000
    } dfs_state_t;

    typedef struct packed {
        logic load;      // request accepted: load operand, clear root/remainder
        logic int_step;  // one integer root bit
        logic int_last;  // last integer step: capture integer root
        logic dig_init;  // scale remainder by 100, form 20*root
        logic dig_try;   // try the next digit candidate
        logic out_load;  // move result into the output register
    } dfs_ctl_t;

    typedef struct packed {
        logic fits;      // subtrahend <= minuend in the shared unit
        logic t_max;     // current digit candidate is the last one
    } dfs_sts_t;

endpackage

// ===== hw/rtl/decimal_fixed_point_sqrt_unit.sv =====
// Top level of the decimal fixed-point square root unit.
// Returns floor(sqrt(value)) and floor(sqrt(value) * 10^d), d = frac_digits capped at
// MAX_FRAC_DIGITS (reset 3). One request is in flight at a time; in_stall is high from
// acceptance until the result is moved to the output register, which frees the input while
// a result still waits downstream. There are INT_STEPS integer steps (16 at the default
// 31-bit input). All work runs through one shared subtract-compare unit: one root bit
// per cycle for the integer part, then one digit candidate per cycle for each decimal digit.
module decimal_fixed_point_sqrt_unit
    import dfs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [VALUE_BITS-1:0]       value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [INT_ROOT_BITS-1:0]    int_root,
    output logic [SCALED_ROOT_BITS-1:0] scaled_root,
    input  logic                        cfg_wr_en,
    input  logic [FRAC_DIGITS_BITS-1:0] cfg_wr_data
);

    dfs_ctl_t ctl;
    dfs_sts_t sts;

    dfs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sts         (sts),
        .ctl         (ctl)
    );

    dfs_datapath u_datapath (
        .clk         (clk),
        .value       (value),
        .ctl         (ctl),
        .sts         (sts),
        .int_root    (int_root),
        .scaled_root (scaled_root)
    );

endmodule

// ===== hw/rtl/dfs_ctrl.sv =====
// Sequencer for the square root unit: handshakes, configuration register, step counters.
module dfs_ctrl
    import dfs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        cfg_wr_en,
    input  logic [FRAC_DIGITS_BITS-1:0] cfg_wr_data,
    input  dfs_sts_t                    sts,
    output dfs_ctl_t                    ctl
);

    dfs_state_t                  state_reg, state_next;
    logic [STEP_W-1:0]           step_cnt_reg, step_cnt_next;
    logic [DIG_W-1:0]            dig_cnt_reg, dig_cnt_next;
    logic [FRAC_DIGITS_BITS-1:0] frac_digits_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [DIG_W-1:0]            digits_sat;
    logic                        dig_finish;

    always_comb
    begin
        if (int'(frac_digits_reg) > MAX_FRAC_DIGITS)
            digits_sat = DIG_W'(MAX_FRAC_DIGITS);
        else
            digits_sat = DIG_W'(frac_digits_reg);
    end

    assign dig_finish = !sts.fits || sts.t_max;

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load      = 1'b1;
                    step_cnt_next = STEP_W'(INT_STEPS - 1);
                    dig_cnt_next  = digits_sat;
                    state_next    = ST_INT;
                end
            end
            ST_INT:
            begin
                ctl.int_step  = 1'b1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0)
                begin
                    ctl.int_last = 1'b1;
                    state_next   = (dig_cnt_reg == '0) ? ST_DONE : ST_DIG_INIT;
                end
            end
            ST_DIG_INIT:
            begin
                ctl.dig_init = 1'b1;
                state_next   = ST_DIG_TRY;
            end
            ST_DIG_TRY:
            begin
                ctl.dig_try = 1'b1;
                if (dig_finish)
                begin
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    state_next   = (dig_cnt_reg == DIG_W'(1)) ? ST_DONE : ST_DIG_INIT;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_cnt_reg    <= '0;
            dig_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            frac_digits_reg <= FRAC_DIGITS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                frac_digits_reg <= cfg_wr_data;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/dfs_datapath.sv =====
// Root/remainder registers around one shared subtract-compare unit, plus the output register.
module dfs_datapath
    import dfs_pkg::*;
(
    input  logic                        clk,
    input  logic [VALUE_BITS-1:0]       value,
    input  dfs_ctl_t                    ctl,
    output dfs_sts_t                    sts,
    output logic [INT_ROOT_BITS-1:0]    int_root,
    output logic [SCALED_ROOT_BITS-1:0] scaled_root
);

    logic [INT_IN_W-1:0]         op_reg;
    logic [WORK_W-1:0]           rem_reg;
    logic [WORK_W-1:0]           base_reg;
    logic [ROOT_W-1:0]           root_reg;
    logic [TDIG_W-1:0]           t_reg;
    logic [INT_STEPS-1:0]        int_root_reg;
    logic [INT_ROOT_BITS-1:0]    int_root_out_reg;
    logic [SCALED_ROOT_BITS-1:0] scaled_out_reg;

    logic [WORK_W-1:0]           shifted;
    logic [WORK_W-1:0]           trial;
    logic [WORK_W-1:0]           inc;
    logic [WORK_W-1:0]           unit_a;
    logic [WORK_W-1:0]           unit_b;
    logic [WORK_W:0]             diff_full;
    logic [TDIG_W-1:0]           t_new;
    logic [ROOT_W-1:0]           root_x10;
    logic [INT_STEPS-1:0]        int_root_next;

    always_comb
    begin
        // integer step: bring down two value bits, trial = 4*root + 1
        shifted = {rem_reg[WORK_W-3:0], op_reg[INT_IN_W-1 -: 2]};
        trial   = WORK_W'({root_reg[INT_STEPS-1:0], 2'b01});
        // digit step: (20r + 2t + 1) is the cost of going from t to t+1
        inc     = base_reg + WORK_W'({t_reg, 1'b1});

        unit_a    = ctl.dig_try ? rem_reg : shifted;
        unit_b    = ctl.dig_try ? inc : trial;
        diff_full = {1'b0, unit_a} - {1'b0, unit_b};
        sts.fits  = !diff_full[WORK_W];
        sts.t_max = (t_reg == DIGIT_LAST_TRY);

        t_new         = sts.fits ? t_reg + 1'b1 : t_reg;
        root_x10      = (root_reg << 3) + (root_reg << 1);
        int_root_next = {root_reg[INT_STEPS-2:0], sts.fits};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= INT_IN_W'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctl.int_step)
        begin
            op_reg   <= op_reg << 2;
            rem_reg  <= sts.fits ? diff_full[WORK_W-1:0] : shifted;
            root_reg <= ROOT_W'(int_root_next);
            if (ctl.int_last)
                int_root_reg <= int_root_next;
        end
        else if (ctl.dig_init)
        begin
            rem_reg  <= (rem_reg << 6) + (rem_reg << 5) + (rem_reg << 2);
            base_reg <= (WORK_W'(root_reg) << 4) + (WORK_W'(root_reg) << 2);
            t_reg    <= '0;
        end
        else if (ctl.dig_try)
        begin
            if (sts.fits)
                rem_reg <= diff_full[WORK_W-1:0];
            t_reg <= t_new;
            if (!sts.fits || sts.t_max)
                root_reg <= root_x10 + ROOT_W'(t_new);
        end

        if (ctl.out_load)
        begin
            int_root_out_reg <= INT_ROOT_BITS'(int_root_reg);
            scaled_out_reg   <= SCALED_ROOT_BITS'(root_reg);
        end
    end

    assign int_root    = int_root_out_reg;
    assign scaled_root = scaled_out_reg;

endmodule

// ===== hw/rtl/dfs_checker.sv =====
// Port-level checks for the square root unit and the bind that attaches them.
module dfs_checker
    import dfs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [INT_ROOT_BITS-1:0]    int_root,
    input  logic [SCALED_ROOT_BITS-1:0] scaled_root
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(int_root) && $stable(scaled_root))
        else $error("result changed while stalled");

    // after a request is taken the unit is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a request");

    // a new result only appears when a request was being worked on
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no request in flight");

    // scaling by a power of ten never lowers the root
    a_scaled_ge_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> SCALED_ROOT_BITS'(int_root) <= scaled_root)
        else $error("scaled root below integer root");

endmodule

bind decimal_fixed_point_sqrt_unit dfs_checker u_dfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .int_root    (int_root),
    .scaled_root (scaled_root)
);
